// ----- rtl/pairwise_diff_and_site_stats_core_defines.svh -----
// Assertion macros shared by the pairwise difference core
`ifndef PAIRWISE_DIFF_AND_SITE_STATS_CORE_DEFINES_SVH
`define PAIRWISE_DIFF_AND_SITE_STATS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types of the pairwise difference and site stats core.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_SEQS_DEF = 8;
  localparam int MAX_LEN_DEF  = 1024;

  // widths that cover the whole parameter range
  localparam int SEQ_W_MAX = 4;
  localparam int LEN_W_MAX = 17;

  localparam int SYM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 11;
  localparam int MUT_W  = 12;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] ST_FEW      = 2'd2;
  localparam logic [STAT_W-1:0] ST_CAPACITY = 2'd3;

  // summary of a finished set, handed from loader to engine
  typedef struct packed {
    logic                 go;
    logic [SEQ_W_MAX-1:0] n;
    logic [LEN_W_MAX-1:0] len;
    logic [STAT_W-1:0]    err;
  } psd_set_t;

  typedef struct packed {
    logic [IDX_W-1:0]  seq_a;
    logic [IDX_W-1:0]  seq_b;
    logic [CNT_W-1:0]  diff_count;
    logic [CNT_W-1:0]  seg_sites;
    logic [CNT_W-1:0]  singleton_sites;
    logic [MUT_W-1:0]  mutations;
    logic [CNT_W-1:0]  used_length;
    logic [STAT_W-1:0] status;
    logic              last;
  } psd_res_t;

endpackage

// ----- rtl/psd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if
// Valid/ready channels for symbol beats in and pair result beats out.
// ----------------------------------------------------------------------------
interface psd_in_if import psd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_sequence;
  logic             end_of_set;

  modport source (output valid, symbol, end_of_sequence, end_of_set, input ready);
  modport sink   (input valid, symbol, end_of_sequence, end_of_set, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  seq_a;
  logic [IDX_W-1:0]  seq_b;
  logic [CNT_W-1:0]  diff_count;
  logic [CNT_W-1:0]  seg_sites;
  logic [CNT_W-1:0]  singleton_sites;
  logic [MUT_W-1:0]  mutations;
  logic [CNT_W-1:0]  used_length;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, seq_a, seq_b, diff_count, seg_sites, singleton_sites,
                  mutations, used_length, status, last, input ready);
  modport sink   (input valid, seq_a, seq_b, diff_count, seg_sites, singleton_sites,
                  mutations, used_length, status, last, output ready);
endinterface

// ----- rtl/psd_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_store
// Symbol memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psd_store import psd_pkg::*; #(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF,
  localparam int SW = $clog2(MAX_SEQS),
  localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int AW = SW + LW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [SYM_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [SYM_W-1:0] rdata_o
);

  localparam int DEPTH = MAX_SEQS * (1 << LW);

  logic [SYM_W-1:0] mem [DEPTH];
  logic [SYM_W-1:0] rdata_q;

  // write symbol beats
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/psd_loader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_loader
// Tracks sequence count, lengths and load errors; writes symbols to memory.
// ----------------------------------------------------------------------------
module psd_loader import psd_pkg::*; #(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF,
  localparam int SW  = $clog2(MAX_SEQS),
  localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int AW  = SW + LW,
  localparam int NW  = $clog2(MAX_SEQS + 1),
  localparam int LW1 = $clog2(MAX_LEN + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             eos_i,
  input  logic             eoset_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic [SYM_W-1:0] wdata_o,
  output psd_set_t         set_o
);

  logic [NW-1:0]     seq_q, seq_d;
  logic [LW1-1:0]    cur_q, cur_d, first_q, first_d;
  logic [STAT_W-1:0] err_q, err_d;
  logic              full;

  assign full    = (seq_q >= NW'(MAX_SEQS)) || (cur_q >= LW1'(MAX_LEN));
  assign we_o    = acc_i && !full;
  assign waddr_o = {seq_q[SW-1:0], cur_q[LW-1:0]};
  assign wdata_o = symbol_i;

  // next load state for one beat
  always_comb begin
    seq_d   = seq_q;
    cur_d   = cur_q;
    first_d = first_q;
    err_d   = err_q;
    if (acc_i) begin
      if (full) begin
        if (err_d == ST_OK) err_d = ST_CAPACITY;
      end else begin
        cur_d = cur_q + LW1'(1);
      end
      if (eos_i || eoset_i) begin
        if (seq_q < NW'(MAX_SEQS)) begin
          if (seq_q == '0) begin
            first_d = cur_d;
          end else if (cur_d != first_q) begin
            if (err_d == ST_OK) err_d = ST_MISMATCH;
          end
          seq_d = seq_q + NW'(1);
        end
        cur_d = '0;
      end
    end
    set_o.go  = acc_i && eoset_i;
    set_o.n   = SEQ_W_MAX'(seq_d);
    set_o.len = LEN_W_MAX'(first_d);
    set_o.err = err_d;
  end

  // hold load state, clear at end of set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      cur_q   <= '0;
      first_q <= '0;
      err_q   <= ST_OK;
    end else if (acc_i && eoset_i) begin
      seq_q   <= '0;
      cur_q   <= '0;
      first_q <= '0;
      err_q   <= ST_OK;
    end else begin
      seq_q   <= seq_d;
      cur_q   <= cur_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/psd_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_engine
// Scans memory column by column, counts pair differences and site stats,
// then emits one result beat per live pair, or one status beat for a failed set.
// ----------------------------------------------------------------------------
`include "pairwise_diff_and_site_stats_core_defines.svh"

module psd_engine import psd_pkg::*; #(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF,
  localparam int SW  = $clog2(MAX_SEQS),
  localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int AW  = SW + LW,
  localparam int NW  = $clog2(MAX_SEQS + 1),
  localparam int LW1 = $clog2(MAX_LEN + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psd_set_t         set_i,
  output logic             busy_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  input  logic [SYM_W-1:0] rdata_i,
  psd_out_if.source        out_o
);

  localparam int NP = MAX_SEQS * (MAX_SEQS - 1) / 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0]        st_q, st_d;
  logic [NW-1:0]     n_q, n_d;
  logic [LW1-1:0]    len_q, len_d, col_q, col_d;
  logic [STAT_W-1:0] err_q, err_d;
  logic [SW-1:0]     s_q, s_d, ri_q, pa_q, pa_d, pb_q, pb_d;
  logic              rv_q;
  logic [SYM_W-1:0]  sym_q [MAX_SEQS];
  logic [NW-1:0]     cnt_q [4];
  logic              unc_q;
  logic [CNT_W-1:0]  used_q, used_d, seg_q, seg_d, sgl_q, sgl_d;
  logic [MUT_W-1:0]  mut_q, mut_d;
  logic [CNT_W-1:0]  diff_q [NP];
  logic [CNT_W-1:0]  diff_d [NP];
  logic              clr_col, clr_acc, shift;
  logic              ov_q, ov_d, ld;
  psd_res_t          res_q, res_d;
  logic [2:0]        n_distinct;
  logic              has1;
  logic              pair_live;

  assign busy_o    = (st_q != S_IDLE);
  assign re_o      = (st_q == S_ISSUE);
  assign raddr_o   = {s_q, col_q[LW-1:0]};
  assign pair_live = (NW'(pb_q) < n_q);

  // distinct states and singleton test of the gathered column
  always_comb begin
    n_distinct = '0;
    has1 = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cnt_q[i] != '0) n_distinct = n_distinct + 3'd1;
      if (cnt_q[i] == NW'(1)) has1 = 1'b1;
    end
  end

  // pair difference counters: bump in eval, shift out in emit
  always_comb begin
    int p;
    p = 0;
    for (int a = 0; a < MAX_SEQS - 1; a++) begin
      for (int b = a + 1; b < MAX_SEQS; b++) begin
        diff_d[p] = diff_q[p];
        if (clr_acc) begin
          diff_d[p] = '0;
        end else if (shift) begin
          diff_d[p] = (p + 1 < NP) ? diff_q[(p + 1) % NP] : '0;
        end else if (st_q == S_EVAL && !unc_q && NW'(b) < n_q
                     && sym_q[a] != sym_q[b]) begin
          diff_d[p] = diff_q[p] + CNT_W'(1);
        end
        p = p + 1;
      end
    end
  end

  // sequencer
  always_comb begin
    st_d    = st_q;
    n_d     = n_q;
    len_d   = len_q;
    err_d   = err_q;
    col_d   = col_q;
    s_d     = s_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    used_d  = used_q;
    seg_d   = seg_q;
    sgl_d   = sgl_q;
    mut_d   = mut_q;
    clr_col = 1'b0;
    clr_acc = 1'b0;
    shift   = 1'b0;
    ld      = 1'b0;
    res_d   = res_q;
    unique case (st_q)
      S_IDLE: begin
        if (set_i.go) begin
          n_d     = NW'(set_i.n);
          len_d   = LW1'(set_i.len);
          err_d   = set_i.err;
          col_d   = '0;
          s_d     = '0;
          pa_d    = '0;
          pb_d    = SW'(1);
          used_d  = '0;
          seg_d   = '0;
          sgl_d   = '0;
          mut_d   = '0;
          clr_acc = 1'b1;
          clr_col = 1'b1;
          if (set_i.err != ST_OK) begin
            st_d = S_ERR;
          end else if (set_i.n < SEQ_W_MAX'(2)) begin
            err_d = ST_FEW;
            st_d  = S_ERR;
          end else if (set_i.len == '0) begin
            st_d = S_EMIT;
          end else begin
            st_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        if (NW'(s_q) + NW'(1) == n_q) begin
          st_d = S_DRAIN;
        end else begin
          s_d = s_q + SW'(1);
        end
      end
      S_DRAIN: st_d = S_EVAL;
      S_EVAL: begin
        if (!unc_q) begin
          used_d = used_q + CNT_W'(1);
          mut_d  = mut_q + MUT_W'(n_distinct) - MUT_W'(1);
          if (n_distinct > 3'd1) begin
            seg_d = seg_q + CNT_W'(1);
            if (has1) sgl_d = sgl_q + CNT_W'(1);
          end
        end
        clr_col = 1'b1;
        s_d     = '0;
        col_d   = col_q + LW1'(1);
        st_d    = (col_q + LW1'(1) == len_q) ? S_EMIT : S_ISSUE;
      end
      S_EMIT: begin
        if (!pair_live || !ov_q || out_o.ready) begin
          if (pair_live) begin
            ld                    = 1'b1;
            res_d.seq_a           = IDX_W'(pa_q);
            res_d.seq_b           = IDX_W'(pb_q);
            res_d.diff_count      = diff_q[0];
            res_d.seg_sites       = seg_q;
            res_d.singleton_sites = sgl_q;
            res_d.mutations       = mut_q;
            res_d.used_length     = used_q;
            res_d.status          = ST_OK;
            res_d.last            = (NW'(pa_q) + NW'(2) == n_q)
                                    && (NW'(pb_q) + NW'(1) == n_q);
          end
          shift = 1'b1;
          if (pb_q == SW'(MAX_SEQS - 1)) begin
            if (pa_q == SW'(MAX_SEQS - 2)) begin
              st_d = S_IDLE;
            end else begin
              pa_d = pa_q + SW'(1);
              pb_d = pa_q + SW'(2);
            end
          end else begin
            pb_d = pb_q + SW'(1);
          end
        end
      end
      S_ERR: begin
        if (!ov_q || out_o.ready) begin
          ld    = 1'b1;
          res_d = '0;
          res_d.status = err_q;
          res_d.last   = 1'b1;
          st_d  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    ov_d = ld ? 1'b1 : (ov_q && !out_o.ready) ? 1'b1 : 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      rv_q <= re_o;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    len_q  <= len_d;
    err_q  <= err_d;
    col_q  <= col_d;
    s_q    <= s_d;
    ri_q   <= s_q;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    used_q <= used_d;
    seg_q  <= seg_d;
    sgl_q  <= sgl_d;
    mut_q  <= mut_d;
    res_q  <= res_d;
    for (int p = 0; p < NP; p++) begin
      diff_q[p] <= diff_d[p];
    end
    // gather one column symbol per read beat
    if (clr_col) begin
      unc_q <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
    end else if (rv_q) begin
      sym_q[ri_q]            <= rdata_i;
      cnt_q[rdata_i[1:0]]    <= cnt_q[rdata_i[1:0]] + NW'(1);
      if (rdata_i > SYM_W'(3)) unc_q <= 1'b1;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.seq_a           = res_q.seq_a;
  assign out_o.seq_b           = res_q.seq_b;
  assign out_o.diff_count      = res_q.diff_count;
  assign out_o.seg_sites       = res_q.seg_sites;
  assign out_o.singleton_sites = res_q.singleton_sites;
  assign out_o.mutations       = res_q.mutations;
  assign out_o.used_length     = res_q.used_length;
  assign out_o.status          = res_q.status;
  assign out_o.last            = res_q.last;

  `PSD_ASSERT_IMP(a_go_idle, set_i.go, st_q == S_IDLE, "set handed over while engine busy")
  `PSD_ASSERT_IMP(a_issue_rng, st_q == S_ISSUE, NW'(s_q) < n_q, "read beyond loaded sequences")
  `PSD_ASSERT_IMP(a_eval_drained, st_q == S_EVAL, !rv_q, "column evaluated before last read")
  `PSD_ASSERT_NXT(a_ld_valid, ld, ov_q, "loaded result not presented")

endmodule

// ----- rtl/pairwise_diff_and_site_stats_core.sv -----
`timescale 1ns / 1ps
// One symbol beat per cycle while loading. After the end-of-set beat, each column of
// the first sequence's length is scanned with one memory read per sequence, a drain
// step and an evaluate step; then the pair slots are walked at one per cycle while the
// output is not held off, emitting a beat for each live pair; an error set gives one beat.
// The single read port of the symbol memory sets the scan rate. Reset clears all control
// state; the symbol memory is not cleared and is only read where written in the set.
// ----------------------------------------------------------------------------
// pairwise_diff_and_site_stats_core
// Loads aligned sequences and reports pairwise differences and site statistics.
// ----------------------------------------------------------------------------
module pairwise_diff_and_site_stats_core import psd_pkg::*; #(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  localparam int AW = $clog2(MAX_SEQS) + ((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1);

  logic             busy, acc, we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [SYM_W-1:0] wdata, rdata;
  psd_set_t         set_info;

  // take beats only while no set is being computed
  assign in_i.ready = !busy;
  assign acc        = in_i.valid && !busy;

  psd_loader #(.MAX_SEQS(MAX_SEQS), .MAX_LEN(MAX_LEN)) u_loader (
    .clk_i, .rst_ni,
    .acc_i(acc), .symbol_i(in_i.symbol), .eos_i(in_i.end_of_sequence),
    .eoset_i(in_i.end_of_set),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .set_o(set_info)
  );

  psd_store #(.MAX_SEQS(MAX_SEQS), .MAX_LEN(MAX_LEN)) u_store (
    .clk_i,
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  psd_engine #(.MAX_SEQS(MAX_SEQS), .MAX_LEN(MAX_LEN)) u_engine (
    .clk_i, .rst_ni,
    .set_i(set_info), .busy_o(busy),
    .re_o(re), .raddr_o(raddr), .rdata_i(rdata),
    .out_o(out_o)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the pairwise difference and site stats core against a behavioral
// predictor. Sets of aligned sequences are streamed in symbol by symbol.
// Directed sets cover errors, extremes and dropped columns; random sets
// follow. Each pair result beat is compared with the predicted one in order.
// ----------------------------------------------------------------------------
module tb_top;
  import psd_pkg::*;

  localparam int NSEQ     = MAX_SEQS_DEF;
  localparam int NLEN     = MAX_LEN_DEF;
  localparam int IDLE_LIM = 100000;

  // Predicts the result beats of each set and checks them in arrival order
  class site_stats_board;
    logic [SYM_W-1:0]  sym_mem [NSEQ][NLEN];
    bit                unc_col [NLEN];
    int                first_len, cur_len, nseq;
    logic [STAT_W-1:0] err;
    psd_res_t          pending[$];
    int                mismatches;

    function void clear_set();
      foreach (unc_col[i]) unc_col[i] = 1'b0;
      first_len = 0;
      cur_len   = 0;
      nseq      = 0;
      err       = ST_OK;
    endfunction

    function void flag_error(logic [STAT_W-1:0] code);
      if (err == ST_OK) err = code;
    endfunction

    function void predict_set();
      psd_res_t r;
      int used, seg, single, mut, diff, distinct, k, total;
      int cnt[4];
      bit has_single;
      if (err == ST_OK && nseq < 2) err = ST_FEW;
      if (err != ST_OK) begin
        r = '0;
        r.status = err;
        r.last = 1'b1;
        pending = {pending, r};
        return;
      end
      used = 0; seg = 0; single = 0; mut = 0;
      for (int c = 0; c < first_len; c++) begin
        if (unc_col[c]) continue;
        used++;
        cnt = '{0, 0, 0, 0};
        for (int s = 0; s < nseq; s++) cnt[sym_mem[s][c][1:0]]++;
        distinct = 0;
        has_single = 1'b0;
        for (int v = 0; v < 4; v++) begin
          if (cnt[v] != 0) distinct++;
          if (cnt[v] == 1) has_single = 1'b1;
        end
        if (distinct > 1) begin
          seg++;
          if (has_single) single++;
        end
        mut += distinct - 1;
      end
      total = nseq * (nseq - 1) / 2;
      k = 0;
      for (int a = 0; a + 1 < nseq; a++) begin
        for (int b = a + 1; b < nseq; b++) begin
          diff = 0;
          for (int c = 0; c < first_len; c++) begin
            if (!unc_col[c] && sym_mem[a][c] != sym_mem[b][c]) diff++;
          end
          r.seq_a           = IDX_W'(a);
          r.seq_b           = IDX_W'(b);
          r.diff_count      = CNT_W'(diff);
          r.seg_sites       = CNT_W'(seg);
          r.singleton_sites = CNT_W'(single);
          r.mutations       = MUT_W'(mut);
          r.used_length     = CNT_W'(used);
          r.status          = ST_OK;
          r.last            = (k + 1 == total);
          pending = {pending, r};
          k++;
        end
      end
    endfunction

    // Update load state with one accepted symbol beat
    function void note_symbol(logic [SYM_W-1:0] sym, bit eq, bit es);
      if (nseq >= NSEQ || cur_len >= NLEN) begin
        flag_error(ST_CAPACITY);
      end else begin
        sym_mem[nseq][cur_len] = sym;
        if (sym > 3) unc_col[cur_len] = 1'b1;
        cur_len++;
      end
      if (eq || es) begin
        if (nseq < NSEQ) begin
          if (nseq == 0) first_len = cur_len;
          else if (cur_len != first_len) flag_error(ST_MISMATCH);
          nseq++;
        end
        cur_len = 0;
      end
      if (es) begin
        predict_set();
        clear_set();
      end
    endfunction

    function void check_result(psd_res_t got);
      psd_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch:\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  psd_in_if  in_if ();
  psd_out_if out_if ();

  pairwise_diff_and_site_stats_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  site_stats_board board = new();

  bit no_idle;
  bit hold_start, hold_taken;
  int hold_cnt, stall_cnt, idle_cycles, beats_sent;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one symbol beat and hold it until accepted
  task automatic send_beat(logic [SYM_W-1:0] sym, bit eq, bit es);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.symbol          <= sym;
    in_if.end_of_sequence <= eq;
    in_if.end_of_set      <= es;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_symbol(sym, eq, es);
    beats_sent++;
  endtask

  // Send one set; pct_mut varies symbols from a column base, pct_unc puts
  // in uncertain codes
  task automatic send_set(int lens[$], int pct_mut, int pct_unc);
    logic [SYM_W-1:0] base [NLEN + 2];
    logic [SYM_W-1:0] sym;
    bit last_seq;
    foreach (base[i]) base[i] = SYM_W'($urandom_range(3));
    for (int s = 0; s < lens.size(); s++) begin
      last_seq = (s == lens.size() - 1);
      for (int c = 0; c < lens[s]; c++) begin
        sym = base[c < NLEN + 2 ? c : 0];
        if ($urandom_range(99) < pct_mut) sym = SYM_W'($urandom_range(3));
        if ($urandom_range(99) < pct_unc) sym = SYM_W'($urandom_range(15, 4));
        if (c == lens[s] - 1)
          send_beat(sym, last_seq ? bit'($urandom_range(1)) : 1'b1, last_seq);
        else
          send_beat(sym, 1'b0, 1'b0);
      end
    end
  endtask

  // Random flags; always closed by an end-of-set beat
  task automatic send_noise(int count);
    for (int i = 0; i < count; i++)
      send_beat(SYM_W'($urandom_range(15)), $urandom_range(3) == 0, 1'b0);
    send_beat(SYM_W'($urandom_range(15)), bit'($urandom_range(1)), 1'b1);
  endtask

  // Receive side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result('{out_if.seq_a, out_if.seq_b, out_if.diff_count, out_if.seg_sites,
                           out_if.singleton_sites, out_if.mutations, out_if.used_length,
                           out_if.status, out_if.last});
    end
    if (hold_start && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      stall_cnt = pick_gap();
      out_if.ready <= (stall_cnt == 0);
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIM) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int lens[$];
    int n, len, mode;
    in_if.valid           = 1'b0;
    in_if.symbol          = '0;
    in_if.end_of_sequence = 1'b0;
    in_if.end_of_set      = 1'b0;
    out_if.ready          = 1'b0;
    rst_ni                = 1'b0;
    board.clear_set();
    board.mismatches = 0;
    beats_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets
    send_set('{1, 1}, 0, 0);
    send_set('{5, 5, 5, 5, 5, 5, 5, 5}, 40, 10);
    send_set('{4}, 30, 0);
    send_beat(4'hF, 1'b1, 1'b1);
    send_set('{3, 4}, 30, 0);
    send_set('{3, 2, 1, 1, 1, 1, 1, 1, 1, 1}, 30, 0);
    send_set('{2, 2, 2, 2, 2, 2, 2, 2, 2}, 30, 0);
    send_set('{3, 3, 3}, 0, 100);
    send_set('{6, 6, 6, 6}, 100, 0);

    // Random sets; the receiver holds off once early on
    hold_start = 1'b1;
    while (beats_sent < 450) begin
      no_idle = ($urandom_range(4) == 0);
      mode = $urandom_range(99);
      lens.delete();
      if (mode < 70) begin
        n = ($urandom_range(19) == 0) ? 1 : $urandom_range(NSEQ, 2);
        len = $urandom_range(12, 1);
        repeat (n) lens = {lens, len};
      end else if (mode < 80) begin
        n = $urandom_range(NSEQ, 2);
        repeat (n) lens = {lens, int'($urandom_range(6, 1))};
      end else if (mode < 90) begin
        n = $urandom_range(NSEQ + 2, NSEQ + 1);
        len = $urandom_range(3, 1);
        repeat (n) lens = {lens, len};
      end
      if (lens.size() > 0)
        send_set(lens, $urandom_range(50), ($urandom_range(2) == 0) ? 0 : $urandom_range(30));
      else
        send_noise($urandom_range(10));
    end
    in_if.valid <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- pairwise_diff_and_site_stats_core.f -----
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_store.sv
rtl/psd_loader.sv
rtl/psd_engine.sv
rtl/pairwise_diff_and_site_stats_core.sv
verif/tb_top.sv
